// File: src/assert_macros.svh
// Assertion helper macros for the surface evaluator checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: src/uts_pkg.sv
// ----------------------------------------------------------------------------
// uts_pkg
// Shared constants, types and CORDIC tables of the umbilic torus evaluator.
// ----------------------------------------------------------------------------
package uts_pkg;
  localparam int CORDIC_STEPS = 16;
  localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int AW = 36;  // Q30 angle width after reduction bookkeeping
  localparam int CW = 34;  // CORDIC x/y width
  localparam int OW = 20;

  localparam logic signed [AW-1:0] Q30_PI      = 36'sh0C90FDAA2;
  localparam logic signed [AW-1:0] Q30_TWO_PI  = 36'sh1921FB544;
  localparam logic signed [AW-1:0] Q30_HALF_PI = 36'sh06487ED51;
  localparam logic signed [CW-1:0] Q30_GAIN    = 34'sh026DD3B6A;

  typedef struct packed {
    logic signed [OW-1:0] pos_x;
    logic signed [OW-1:0] pos_y;
    logic signed [OW-1:0] pos_z;
    logic signed [OW-1:0] du_x;
    logic signed [OW-1:0] du_y;
    logic signed [OW-1:0] du_z;
    logic signed [OW-1:0] dv_x;
    logic signed [OW-1:0] dv_y;
    logic signed [OW-1:0] dv_z;
  } result_t;

  typedef struct packed {
    logic signed [15:0] u_angle;
    logic signed [15:0] v_angle;
  } request_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] z;
    logic                 flip;
  } cordic_t;

  function automatic logic signed [AW-1:0] atan_q30(input int i);
    logic signed [AW-1:0] r;
    case (i)
      0: r = 36'sh03243F6A8;  1: r = 36'sh01DAC6705;  2: r = 36'sh00FADBAFC;
      3: r = 36'sh007F56EA6;  4: r = 36'sh003FEAB76;  5: r = 36'sh001FFD55B;
      6: r = 36'sh000FFFAAA;  7: r = 36'sh0007FFF55;  8: r = 36'sh0003FFFEA;
      9: r = 36'sh0001FFFFD; 10: r = 36'sh0000FFFFF; 11: r = 36'sh00007FFFF;
      12: r = 36'sh00003FFFF; 13: r = 36'sh00001FFFF; 14: r = 36'sh00000FFFF;
      15: r = 36'sh000007FFF; 16: r = 36'sh000003FFF; 17: r = 36'sh000001FFF;
      18: r = 36'sh000000FFF; 19: r = 36'sh0000007FF; 20: r = 36'sh0000003FF;
      21: r = 36'sh0000001FF; 22: r = 36'sh0000000FF; 23: r = 36'sh00000007F;
      24: r = 36'sh00000003F; 25: r = 36'sh00000001F; 26: r = 36'sh00000000F;
      27: r = 36'sh000000008; 28: r = 36'sh000000004; 29: r = 36'sh000000002;
      30: r = 36'sh000000001;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Reduce a Q30 angle (|a| < 3*pi) to [-pi/2, pi/2]; returns start vector.
  function automatic cordic_t cordic_init(input logic signed [AW-1:0] a_in);
    logic signed [AW-1:0] a;
    cordic_t c;
    a = a_in;
    for (int k = 0; k < 2; k++) begin
      if (a > Q30_PI) a = a - Q30_TWO_PI;
      else if (a < -Q30_PI) a = a + Q30_TWO_PI;
    end
    c.flip = 1'b0;
    if (a > Q30_HALF_PI) begin
      a = a - Q30_PI;
      c.flip = 1'b1;
    end else if (a < -Q30_HALF_PI) begin
      a = a + Q30_PI;
      c.flip = 1'b1;
    end
    c.x = Q30_GAIN;
    c.y = '0;
    c.z = a;
    return c;
  endfunction

  function automatic cordic_t cordic_iter(input cordic_t c, input int i);
    cordic_t r;
    logic signed [CW-1:0] xs, ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    r = c;
    if (!c.z[AW-1]) begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - atan_q30(i);
    end else begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + atan_q30(i);
    end
    return r;
  endfunction
endpackage

// File: src/uts_stream_if.sv
// ----------------------------------------------------------------------------
// uts_stream_if
// Valid/ready channel carrying one payload of a parameter type.
// ----------------------------------------------------------------------------
interface uts_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/uts_cordic.sv
// ----------------------------------------------------------------------------
// uts_cordic
// Three parallel angle pipelines: setup, reduction, one CORDIC step per stage,
// rounding to Q24. Advances when en is high.
// ----------------------------------------------------------------------------
module uts_cordic (
  input  logic                        clk,
  input  logic                        en,
  input  uts_pkg::request_t           req,
  output logic signed [25:0]          sc [6]
);
  import uts_pkg::*;

  logic signed [AW-1:0] ang [3];
  cordic_t pipe [NSTEP+1][3];
  logic [32:0] third_mag;
  logic third_neg;
  logic signed [AW-1:0] u30, v30;

  // |u| * 2^17 / 3 by reciprocal multiply, exact for |u| <= 2^15
  always_ff @(posedge clk) begin
    logic [15:0] mag;
    logic [49:0] prod;
    if (en) begin
      mag = req.u_angle[15] ? 16'(-req.u_angle) : req.u_angle;
      prod = 50'(mag) * 50'(34'h155555556);
      third_mag <= prod[49:17];
      third_neg <= req.u_angle[15];
      u30 <= AW'(req.u_angle) <<< 17;
      v30 <= AW'(req.v_angle) <<< 17;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [AW-1:0] third;
    if (en) begin
      third = third_neg ? -AW'(third_mag) : AW'(third_mag);
      ang[0] <= u30;
      ang[1] <= third - (v30 <<< 1);
      ang[2] <= third + v30;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) pipe[0][k] <= cordic_init(ang[k]);
    end
  end

  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) pipe[s+1][k] <= cordic_iter(pipe[s][k], s);
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [CW-1:0] xx, yy, sy, sx;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        xx = pipe[NSTEP][k].flip ? -pipe[NSTEP][k].x : pipe[NSTEP][k].x;
        yy = pipe[NSTEP][k].flip ? -pipe[NSTEP][k].y : pipe[NSTEP][k].y;
        sy = (yy + CW'(32)) >>> 6;
        sx = (xx + CW'(32)) >>> 6;
        sc[2*k]   <= sy[25:0];
        sc[2*k+1] <= sx[25:0];
      end
    end
  end
endmodule

// File: src/uts_combine.sv
// ----------------------------------------------------------------------------
// uts_combine
// Forms F, G, H, the products and the Q14 rounding in four stages.
// ----------------------------------------------------------------------------
module uts_combine (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [25:0]    sc [6],
  output uts_pkg::result_t      res
);
  import uts_pkg::*;

  logic signed [25:0] su, cu;
  logic signed [28:0] f, h, z_sum, zb;
  logic [25:0] g_mag, g2_mag;
  logic g_neg, g2_neg;
  logic signed [25:0] su2, cu2;
  logic signed [28:0] f2, h2, z2, zb2, g, g2;
  logic signed [55:0] pf_s, pf_c, pg_s, pg_c, ph_s, ph_c;
  logic signed [28:0] z3, g3, zb3;

  function automatic logic signed [OW-1:0] rnd(input logic signed [55:0] v,
                                                 input int s);
    logic signed [55:0] t;
    t = (v + (56'sd1 <<< (s - 1))) >>> s;
    return t[OW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    logic signed [28:0] sa, ca, sb, cb, gn, gn2;
    if (en) begin
      sa = 29'(sc[2]); ca = 29'(sc[3]); sb = 29'(sc[4]); cb = 29'(sc[5]);
      gn = (sb <<< 1) + sa;
      gn2 = (cb <<< 1) + ca;
      su <= sc[0];
      cu <= sc[1];
      f <= (29'sd7 <<< 24) + ca + (cb <<< 1);
      h <= sa - sb;
      z_sum <= sa + (sb <<< 1);
      zb <= cb - ca;
      g_neg <= gn[28];
      g_mag <= gn[28] ? 26'(-gn) : 26'(gn);
      g2_neg <= gn2[28];
      g2_mag <= gn2[28] ? 26'(-gn2) : 26'(gn2);
    end
  end

  // divide by 3 toward zero: magnitude times ceil(2^28/3), exact below 2^27
  always_ff @(posedge clk) begin
    logic [53:0] qg, qg2;
    if (en) begin
      qg = 54'(g_mag) * 54'(27'd89478486);
      qg2 = 54'(g2_mag) * 54'(27'd89478486);
      g <= g_neg ? -29'(qg[53:28]) : 29'(qg[53:28]);
      g2 <= g2_neg ? -29'(qg2[53:28]) : 29'(qg2[53:28]);
      su2 <= su;
      cu2 <= cu;
      f2 <= f;
      h2 <= h;
      z2 <= z_sum;
      zb2 <= zb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pf_s <= 56'(su2) * 56'(f2);
      pf_c <= 56'(cu2) * 56'(f2);
      pg_s <= 56'(su2) * 56'(g);
      pg_c <= 56'(cu2) * 56'(g);
      ph_s <= 56'(su2) * 56'(h2);
      ph_c <= 56'(cu2) * 56'(h2);
      z3 <= z2; g3 <= g2; zb3 <= zb2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.pos_x <= rnd(pf_s, 34);
      res.pos_y <= rnd(pf_c, 34);
      res.pos_z <= rnd(56'(z3), 10);
      res.du_x  <= rnd(pf_c - pg_s, 34);
      res.du_y  <= rnd(-pf_s - pg_c, 34);
      res.du_z  <= rnd(56'(g3), 10);
      res.dv_x  <= rnd(ph_s, 34);
      res.dv_y  <= rnd(ph_c, 34);
      res.dv_z  <= rnd(56'(zb3), 10);
    end
  end
endmodule

// File: src/umbilic_torus_surface_eval_core.sv
// ----------------------------------------------------------------------------
// umbilic_torus_surface_eval_core
// Umbilic torus point and partial derivatives from (u, v), pipelined.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_ch   | in  | u_angle, v_angle (Q3.13)
//  out_ch  | out | pos/du/dv x,y,z (Q6.14)
// One transaction per cycle while the output is not stalled. Four setup and
// rounding stages around the CORDIC step chain, then four combine stages.
// Reset clears the valid bits only. A stall at the output freezes the whole
// pipeline; nothing is dropped or repeated.
module umbilic_torus_surface_eval_core (
  input logic clk,
  input logic rst,
  uts_stream_if.sink   in_ch,
  uts_stream_if.source out_ch
);
  import uts_pkg::*;

  localparam int LAT = NSTEP + 8;
  logic [LAT-1:0] vld;
  logic en;
  logic signed [25:0] sc [6];
  result_t res;

  assign en = !vld[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_ch.valid};
    end
  end

  uts_cordic u_cordic (.clk(clk), .en(en), .req(in_ch.data), .sc(sc));
  uts_combine u_comb (.clk(clk), .en(en), .sc(sc), .res(res));

  assign out_ch.valid = vld[LAT-1];
  assign out_ch.data  = res;
endmodule

// File: src/uts_checker.sv
// ----------------------------------------------------------------------------
// uts_checker
// Port-level checks for the umbilic torus evaluator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module uts_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  `ASSERT_IMPL(a_ready_free, clk, rst, !out_valid, in_ready, "ready low with empty output")
  `ASSERT_IMPL(a_ready_stall, clk, rst, out_valid && !out_ready, !in_ready, "ready high in stall")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "output dropped")
endmodule

bind umbilic_torus_surface_eval_core uts_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
